>>> rtl/plpp_pkg.sv
// Package for the piecewise-linear profile player: shared types, codes and sizes.
`timescale 1ns / 1ps
package plpp_pkg;

  // Table depth; point_index is six bits wide, so every index addresses the table.
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned COUNT_W    = 7;
  // Quotient bits of the divider, one per cell of the chain.
  localparam int unsigned DIV_W      = 32;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] CFG_POINT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_LOOP_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_INITIAL_TEMP = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         point_index;
    logic [31:0]        point_time_ms;
    logic signed [15:0] point_depth;
    logic signed [15:0] point_temp;
    logic [31:0]        elapsed_ms;
  } req_t;

  typedef struct packed {
    logic signed [15:0] depth_out;
    logic signed [15:0] temp_out;
  } res_t;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] word;
  } div_stage_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_MOD_ISS,
    S_MOD_WAIT,
    S_SCAN,
    S_MUL,
    S_DIV_D,
    S_DIV_T,
    S_DIV_WAIT
  } plpp_state_t;

endpackage

>>> rtl/plpp_div_cell.sv
// One cell of the divider chain: a single restoring quotient bit per cycle.
`timescale 1ns / 1ps
module plpp_div_cell
  import plpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [DIV_W-1:0] divisor,
  input  div_stage_t       prev,
  output div_stage_t       next
);

  logic [DIV_W:0] cand;
  logic [DIV_W:0] diff;
  logic           ge;

  // The word shifts left: dividend bits leave at the top, quotient bits enter below.
  assign cand = {prev.rem, prev.word[DIV_W-1]};
  assign diff = cand - {1'b0, divisor};
  assign ge   = cand >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= prev.valid;
    end
    next.rem  <= ge ? diff[DIV_W-1:0] : cand[DIV_W-1:0];
    next.word <= {prev.word[DIV_W-2:0], ge};
  end

endmodule

>>> rtl/plpp_div_chain.sv
// Row of divider cells, one per quotient bit, giving quotient and remainder.
`timescale 1ns / 1ps
module plpp_div_chain
  import plpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [DIV_W-1:0] divisor,
  input  div_stage_t       din,
  output div_stage_t       dout
);

  div_stage_t link [DIV_W+1];

  assign link[0] = din;

  for (genvar g = 0; g < DIV_W; g++) begin : g_cell
    plpp_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .divisor (divisor),
      .prev    (link[g]),
      .next    (link[g+1])
    );
  end

  assign dout = link[DIV_W];

endmodule

>>> rtl/piecewise_linear_profile_player.sv
// Top level of the piecewise-linear profile player: table, sequencer and divider chain.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+----------------------------
//  request  | in        | start high while busy low  | req (req_t)
//  result   | out       | done, one cycle, no stall  | result (res_t)
//  config   | in        | cfg_valid and cfg_ready    | cfg_index, cfg_data
//
//  A load transfer writes the table in the cycle it is accepted and leaves busy low.
//  A sample goes from acceptance to done through these steps: fetch the last time, the
//  loop wrap when enabled, a search of the table entry by entry, the two interpolation
//  divides, which share the 32-cell chain and are issued from S_DIV_D and then S_DIV_T,
//  and the result register. Reset clears the sequencer, the strobe and the configuration
//  registers; the table itself is not cleared. The receiver cannot stall.
//
module piecewise_linear_profile_player
  import plpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Maps a negative depth to the surface.
  function automatic logic signed [15:0] clamp0(input logic signed [15:0] v);
    return v[15] ? 16'sd0 : v;
  endfunction

  plpp_state_t state, state_next;

  // Configuration registers.
  logic [COUNT_W-1:0] point_count;
  logic               loop_enable;
  logic signed [15:0] initial_temp;

  // The profile table, one memory per field, with registered read data.
  logic [31:0]        time_mem  [MAX_POINTS];
  logic signed [15:0] depth_mem [MAX_POINTS];
  logic signed [15:0] temp_mem  [MAX_POINTS];
  logic [ADDR_W-1:0]  rd_addr;
  logic [31:0]        rd_time;
  logic signed [15:0] rd_depth;
  logic signed [15:0] rd_temp;
  logic               mem_we;

  // Sample working registers.
  logic [31:0]        t_q;
  logic [COUNT_W-1:0] n_q;
  logic [ADDR_W-1:0]  idx;
  logic [31:0]        prev_time;
  logic signed [15:0] prev_depth;
  logic signed [15:0] prev_temp;
  logic [31:0]        div_d;
  logic [31:0]        num_q;
  logic signed [16:0] diff_d;
  logic signed [16:0] diff_t;
  logic signed [48:0] prod_d;
  logic signed [48:0] prod_t;
  logic signed [15:0] q_depth;
  logic               got_depth;

  // Derived values.
  logic               accept;
  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] n_m1;
  logic               hit;
  logic               at_last;
  logic [31:0]        span;
  logic [31:0]        num;
  logic [48:0]        mag_d;
  logic [48:0]        mag_t;
  logic signed [15:0] lerp_base;
  logic               lerp_neg;
  logic [17:0]        q18;
  logic [17:0]        lerp_sum;
  logic               fin;
  res_t               fin_res;

  div_stage_t div_in, div_out;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // A count above the table depth is treated as a full table.
  assign n_eff   = (point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
  assign n_m1    = n_eff - COUNT_W'(1);
  assign hit     = t_q <= rd_time;
  assign at_last = {1'b0, idx} == (n_q - COUNT_W'(1));
  assign span    = rd_time - prev_time;
  assign num     = t_q - prev_time;

  // The divider works on magnitudes so that the quotient truncates toward zero.
  assign mag_d = prod_d[48] ? $unsigned(-prod_d) : $unsigned(prod_d);
  assign mag_t = prod_t[48] ? $unsigned(-prod_t) : $unsigned(prod_t);

  // The depth quotient leaves the chain first and the temperature in the cycle after it.
  // Because the offset into the segment never exceeds the span, each quotient is no
  // larger than the difference of the two points and the sum stays between them.
  assign lerp_base = got_depth ? prev_temp : prev_depth;
  assign lerp_neg  = got_depth ? prod_t[48] : prod_d[48];
  assign q18       = {1'b0, div_out.word[16:0]};
  assign lerp_sum  = {{2{lerp_base[15]}}, lerp_base} + (lerp_neg ? (18'd0 - q18) : q18);

  plpp_div_chain u_div (
    .clk     (clk),
    .rst     (rst),
    .divisor (div_d),
    .din     (div_in),
    .dout    (div_out)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && req.req_type == REQ_SAMPLE && n_eff != '0) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = (loop_enable && rd_time != '0) ? S_MOD_ISS : S_SCAN;
      end
      S_MOD_ISS: begin
        state_next = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (div_out.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (idx == '0 || span == '0) ? S_IDLE : S_MUL;
        end else if (at_last) begin
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        state_next = S_DIV_D;
      end
      S_DIV_D: begin
        state_next = S_DIV_T;
      end
      S_DIV_T: begin
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_out.valid && got_depth) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output and control logic of the sequencer.
  always_comb begin
    busy      = state != S_IDLE;
    mem_we    = 1'b0;
    rd_addr   = '0;
    div_in    = '0;
    fin       = 1'b0;
    fin_res   = '0;
    unique case (state)
      S_IDLE: begin
        // Look up the last point's time straight away; the wrap needs it.
        rd_addr = n_m1[ADDR_W-1:0];
        mem_we  = accept && req.req_type == REQ_LOAD;
        if (accept && req.req_type == REQ_SAMPLE && n_eff == '0) begin
          fin              = 1'b1;
          fin_res.temp_out = initial_temp;
        end
      end
      S_MOD_ISS: begin
        div_in.valid = 1'b1;
        div_in.word  = t_q;
      end
      S_SCAN: begin
        rd_addr = idx + ADDR_W'(1);
        if (hit) begin
          // Before the first point, or a segment of zero span: the point as stored.
          if (idx == '0 || span == '0) begin
            fin               = 1'b1;
            fin_res.depth_out = rd_depth;
            fin_res.temp_out  = rd_temp;
          end
        end else if (at_last) begin
          // Past the end the last point is held.
          fin               = 1'b1;
          fin_res.depth_out = clamp0(rd_depth);
          fin_res.temp_out  = rd_temp;
        end
      end
      S_DIV_D: begin
        div_in.valid = 1'b1;
        div_in.rem   = {16'd0, mag_d[47:32]};
        div_in.word  = mag_d[31:0];
      end
      S_DIV_T: begin
        div_in.valid = 1'b1;
        div_in.rem   = {16'd0, mag_t[47:32]};
        div_in.word  = mag_t[31:0];
      end
      S_DIV_WAIT: begin
        if (div_out.valid && got_depth) begin
          fin               = 1'b1;
          fin_res.depth_out = q_depth;
          fin_res.temp_out  = lerp_sum[15:0];
        end
      end
      S_LAST, S_MOD_WAIT, S_MUL: begin
        fin = 1'b0;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= '0;
      loop_enable  <= 1'b0;
      initial_temp <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINT_COUNT:  point_count  <= cfg_data[COUNT_W-1:0];
        CFG_LOOP_ENABLE:  loop_enable  <= cfg_data[0];
        CFG_INITIAL_TEMP: initial_temp <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Profile table.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[req.point_index]  <= req.point_time_ms;
      depth_mem[req.point_index] <= req.point_depth;
      temp_mem[req.point_index]  <= req.point_temp;
    end
    rd_time  <= time_mem[rd_addr];
    rd_depth <= depth_mem[rd_addr];
    rd_temp  <= temp_mem[rd_addr];
  end

  // Sequencer state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  // Sample datapath.
  always_ff @(posedge clk) begin
    if (fin) begin
      result <= fin_res;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          t_q <= req.elapsed_ms;
          n_q <= n_eff;
        end
      end
      S_LAST: begin
        div_d <= rd_time;
        idx   <= '0;
      end
      S_MOD_WAIT: begin
        if (div_out.valid) begin
          t_q <= div_out.rem;
        end
      end
      S_SCAN: begin
        if (hit) begin
          div_d  <= span;
          num_q  <= num;
          diff_d <= {rd_depth[15], rd_depth} - {prev_depth[15], prev_depth};
          diff_t <= {rd_temp[15], rd_temp} - {prev_temp[15], prev_temp};
        end else begin
          prev_time  <= rd_time;
          prev_depth <= rd_depth;
          prev_temp  <= rd_temp;
          idx        <= idx + ADDR_W'(1);
        end
      end
      S_MUL: begin
        prod_d    <= diff_d * $signed({1'b0, num_q});
        prod_t    <= diff_t * $signed({1'b0, num_q});
        got_depth <= 1'b0;
      end
      S_DIV_WAIT: begin
        if (div_out.valid && !got_depth) begin
          q_depth   <= clamp0(lerp_sum[15:0]);
          got_depth <= 1'b1;
        end
      end
      S_MOD_ISS, S_DIV_D, S_DIV_T: begin
        got_depth <= got_depth;
      end
      default: begin
        got_depth <= got_depth;
      end
    endcase
  end

endmodule

>>> rtl/plpp_checker.sv
// Port-level checks of the profile player, bound to the top level.
`timescale 1ns / 1ps
module plpp_checker
  import plpp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done
);

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  // A load transfer never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.req_type == REQ_LOAD |=> !done)
    else $error("result after a load");

  // A sample transfer either answers at once or keeps the block busy.
  a_sample_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.req_type == REQ_SAMPLE |=> busy || done)
    else $error("sample dropped");

  // A result only follows work in progress or a transfer just taken.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result without a request");

endmodule

bind piecewise_linear_profile_player plpp_checker u_plpp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done)
);
